// File: design/sfed_pkg.sv
// Package with the frame decoder's types, command codes and status mapping.
`timescale 1ns / 1ps

package sfed_pkg;

    localparam int unsigned KEEP_BYTES = 6;
    localparam int unsigned KEEP_IDX_W = $clog2(KEEP_BYTES);

    localparam logic [7:0] START_BYTE_RESET  = 8'hAA;
    localparam logic [7:0] BOARD_INDEX_RESET = 8'h01;
    localparam logic [7:0] PRIZE_SERIAL_RESET = 8'hFF;

    localparam logic [7:0] CMD_QUERY   = 8'h01;
    localparam logic [7:0] CMD_SCORE   = 8'h03;
    localparam logic [7:0] CMD_ACCOUNT = 8'h04;
    localparam logic [7:0] CMD_END     = 8'hA2;
    localparam logic [7:0] CMD_PRIZE   = 8'h13;

    localparam logic [7:0] SCORE_WIN      = 8'h01;
    localparam logic [7:0] DEV_ERR_BASE   = 8'hE0;
    localparam logic [7:0] DEV_ERR_FIRST  = 8'hE1;
    localparam logic [7:0] DEV_ERR_LAST   = 8'hE8;

    typedef enum logic [1:0] {
        EV_PAY      = 2'd0,
        EV_GAME_END = 2'd1,
        EV_PRIZE    = 2'd2,
        EV_ACCOUNT  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    // Device error bytes 0xE1..0xE8 map to 1..8; anything else is normal.
    function automatic logic [3:0] map_status(input logic [7:0] b);
        logic [7:0] diff;
        diff = b - DEV_ERR_BASE;
        if (b inside {[DEV_ERR_FIRST:DEV_ERR_LAST]})
            return diff[3:0];
        return 4'd0;
    endfunction

endpackage

// File: design/serial_frame_event_decoder.sv
// Top level of the serial frame event decoder.
`timescale 1ns / 1ps
// A taken byte is registered in the input register, then decoded into the result register
// once that register can take it, and a frame's result is shown from there.
// Throughput: one byte per cycle; the result register, when stalled, is the only backpressure.
// Reset (rst_n, asynchronous, active low) puts the parser into start-byte hunting, sets the
// start byte to 0xAA, the board index to 1, forgets any prize serial and empties both stages.
module serial_frame_event_decoder (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [7:0]              cfg_data,
    // received byte channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              rx_byte,
    // event channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              event_res,
    output logic                    success,
    output logic [3:0]              device_status,
    output logic [7:0]              board_id
);
    import sfed_pkg::*;

    // Start byte reg, writes always taken; user must only write while block is idle, unenforced.
    logic [7:0] start_byte_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_byte_reg <= START_BYTE_RESET;
        else if (cfg_valid && cfg_ready)
            start_byte_reg <= cfg_data;
    end

    // Input register. A byte is decoded once the result register can take whatever the byte
    // produces, which is whenever the result register is empty or being drained this cycle.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       proc_en;
    logic       out_valid_reg;

    assign proc_en  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !proc_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= rx_byte;
    end

    // Parser state.
    phase_t     phase_reg, phase_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [8:0] body_count_reg, body_count_next;
    logic [7:0] frame_bytes_reg [KEEP_BYTES];
    logic [7:0] frame_bytes_next [KEEP_BYTES];
    logic       prize_seen_reg, prize_seen_next;
    logic [7:0] last_prize_serial_reg, last_prize_serial_next;
    logic [7:0] board_index_reg, board_index_next;

    // Body byte bookkeeping. The incremented count reaches the length plus one, which is why it is
    // one bit wider than the length byte.
    logic [8:0] body_count_inc;
    logic [8:0] body_total;
    logic       frame_done;
    logic       start_hit;
    logic       keep_slot;

    assign body_count_inc = body_count_reg + 9'd1;
    assign body_total     = {1'b0, frame_length_reg} + 9'd1;
    assign frame_done     = (phase_reg == PH_BODY) && (body_count_inc >= body_total);
    assign start_hit      = (in_byte_reg == start_byte_reg);
    assign keep_slot      = (body_count_reg < 9'(KEEP_BYTES));

    // Frame positions 2..7 as they stand once the current body byte is included, so that
    // the dispatch on the final byte sees a complete frame.
    logic [7:0] frame_view [KEEP_BYTES];

    always_comb
    begin
        for (int i = 0; i < KEEP_BYTES; i++)
        begin
            if (body_count_reg == 9'(i))
                frame_view[i] = in_byte_reg;
            else
                frame_view[i] = frame_bytes_reg[i];
        end
    end

    // Next phase. An unused phase code behaves like hunting.
    always_comb
    begin
        phase_next = phase_reg;
        if (proc_en)
        begin
            case (phase_reg)
                PH_LEN:
                    phase_next = PH_BODY;
                PH_BODY:
                    phase_next = frame_done ? PH_HUNT : PH_BODY;
                default:
                    phase_next = start_hit ? PH_LEN : PH_HUNT;
            endcase
        end
    end

    // Data path and command dispatch.
    logic       res_load;
    event_t     res_event;
    logic       res_success;
    logic [3:0] res_status;
    logic       new_prize;

    assign new_prize = !prize_seen_reg || (last_prize_serial_reg != frame_view[2]);

    always_comb
    begin
        frame_length_next      = frame_length_reg;
        body_count_next        = body_count_reg;
        frame_bytes_next       = frame_bytes_reg;
        prize_seen_next        = prize_seen_reg;
        last_prize_serial_next = last_prize_serial_reg;
        board_index_next       = board_index_reg;
        res_load               = 1'b0;
        res_event              = EV_PAY;
        res_success            = 1'b0;
        res_status             = 4'd0;

        if (proc_en)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    frame_length_next = in_byte_reg;
                    body_count_next   = 9'd0;
                end
                PH_BODY:
                begin
                    if (keep_slot)
                        frame_bytes_next[body_count_reg[KEEP_IDX_W-1:0]] = in_byte_reg;
                    if (frame_done)
                    begin
                        body_count_next = 9'd0;
                        // The command byte sits at frame position 3.
                        case (frame_view[1])
                            CMD_QUERY:
                            begin
                                board_index_next = frame_view[0];
                                res_load         = 1'b1;
                                res_event        = EV_PAY;
                                res_success      = 1'b1;
                            end
                            CMD_SCORE:
                            begin
                                res_load    = 1'b1;
                                res_event   = EV_PAY;
                                res_success = (frame_view[2] == SCORE_WIN);
                            end
                            CMD_END:
                            begin
                                res_load    = 1'b1;
                                res_event   = EV_GAME_END;
                                res_success = 1'b1;
                            end
                            CMD_PRIZE:
                            begin
                                // A repeated serial number is a duplicate report and is dropped.
                                if (new_prize)
                                begin
                                    res_load               = 1'b1;
                                    res_event              = EV_PRIZE;
                                    res_success            = (frame_view[5] != 8'd0);
                                    res_status             = map_status(frame_view[3]);
                                    last_prize_serial_next = frame_view[2];
                                    prize_seen_next        = 1'b1;
                                end
                            end
                            CMD_ACCOUNT:
                            begin
                                res_load    = 1'b1;
                                res_event   = EV_ACCOUNT;
                                res_success = 1'b1;
                                res_status  = map_status(frame_view[2]);
                            end
                            default:
                            begin
                                res_load = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        body_count_next = body_count_inc;
                    end
                end
                default:
                begin
                    // Opening a frame clears the kept positions so that short frames read
                    // zero where they do not reach.
                    if (start_hit)
                    begin
                        for (int i = 0; i < KEEP_BYTES; i++)
                            frame_bytes_next[i] = 8'd0;
                        body_count_next = 9'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_HUNT;
            frame_length_reg      <= 8'd0;
            body_count_reg        <= 9'd0;
            prize_seen_reg        <= 1'b0;
            last_prize_serial_reg <= PRIZE_SERIAL_RESET;
            board_index_reg       <= BOARD_INDEX_RESET;
            for (int i = 0; i < KEEP_BYTES; i++)
                frame_bytes_reg[i] <= 8'd0;
        end
        else
        begin
            phase_reg             <= phase_next;
            frame_length_reg      <= frame_length_next;
            body_count_reg        <= body_count_next;
            prize_seen_reg        <= prize_seen_next;
            last_prize_serial_reg <= last_prize_serial_next;
            board_index_reg       <= board_index_next;
            frame_bytes_reg       <= frame_bytes_next;
        end
    end

    // Result register. It holds one event beat until the receiver stops stalling; a new
    // event can be loaded in the same cycle that the old one leaves.
    logic       out_valid_next;
    logic [1:0] event_res_reg;
    logic       success_reg;
    logic [3:0] device_status_reg;
    logic [7:0] board_id_reg;

    assign out_valid_next = res_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            event_res_reg     <= res_event;
            success_reg       <= res_success;
            device_status_reg <= res_status;
            board_id_reg      <= board_index_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_res     = event_res_reg;
    assign success       = success_reg;
    assign device_status = device_status_reg;
    assign board_id      = board_id_reg;

`ifndef ASSERT_OFF
    // Input backpressure only ever comes from a full result register that is itself stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a stalled result");

    // Inside a frame body the count never passes the number of bytes the length asks for.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (body_count_reg <= {1'b0, frame_length_reg}))
        else $error("body count ran past the frame length");

    // The board index only changes together with a new event, so a waiting event always
    // carries the current index.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (board_id_reg == board_index_reg))
        else $error("waiting event disagrees with board index");

    // A prize event always leaves its serial number remembered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (res_event == EV_PRIZE)) |=> (prize_seen_reg
            && (last_prize_serial_reg == $past(frame_view[2]))))
        else $error("prize serial not recorded");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for the serial frame event decoder: directed and random framed byte traffic.
`timescale 1ns / 1ps

module tb;
    import sfed_pkg::*;

    // One decoded event as it leaves the block.
    typedef struct packed {
        event_t     ev;
        logic       ok;
        logic [3:0] status;
        logic [7:0] board;
    } frame_event_t;

    // The tracker follows the received byte stream with its own copy of the
    // parser state, predicts the event that each completed frame gives, and
    // checks the events that the block delivers in order.
    class frame_decode_tracker;
        logic [7:0]   start_byte;
        phase_t       parse_phase;
        logic [7:0]   frame_len;
        logic [8:0]   body_cnt;
        logic [7:0]   kept [0:5];
        bit           prize_seen;
        logic [7:0]   last_serial;
        logic [7:0]   board_index;
        frame_event_t expected_events [$];
        int           errors;

        function new();
            start_byte  = START_BYTE_RESET;
            parse_phase = PH_HUNT;
            frame_len   = 8'd0;
            body_cnt    = 9'd0;
            foreach (kept[i])
                kept[i] = 8'd0;
            prize_seen  = 1'b0;
            last_serial = PRIZE_SERIAL_RESET;
            board_index = BOARD_INDEX_RESET;
            errors      = 0;
        endfunction

        function logic [3:0] status_of(input logic [7:0] b);
            if (b >= DEV_ERR_FIRST && b <= DEV_ERR_LAST)
                return b[3:0];
            return 4'd0;
        endfunction

        function void push_event(input event_t ev, input logic ok, input logic [3:0] st);
            frame_event_t e;
            e.ev     = ev;
            e.ok     = ok;
            e.status = st;
            e.board  = board_index;
            expected_events.push_back(e);
        endfunction

        // Acts on the command byte of a completed frame.
        function void decode_frame();
            case (kept[1])
                CMD_QUERY: begin
                    board_index = kept[0];
                    push_event(EV_PAY, 1'b1, 4'd0);
                end
                CMD_SCORE:   push_event(EV_PAY, kept[2] == SCORE_WIN, 4'd0);
                CMD_END:     push_event(EV_GAME_END, 1'b1, 4'd0);
                CMD_PRIZE: begin
                    if (!prize_seen || last_serial != kept[2]) begin
                        push_event(EV_PRIZE, kept[5] != 8'd0, status_of(kept[3]));
                        last_serial = kept[2];
                        prize_seen  = 1'b1;
                    end
                end
                CMD_ACCOUNT: push_event(EV_ACCOUNT, 1'b1, status_of(kept[2]));
                default: ;
            endcase
        endfunction

        function void note_byte(input logic [7:0] b);
            case (parse_phase)
                PH_LEN: begin
                    frame_len   = b;
                    body_cnt    = 9'd0;
                    parse_phase = PH_BODY;
                end
                PH_BODY: begin
                    if (body_cnt < 9'd6)
                        kept[body_cnt] = b;
                    body_cnt = body_cnt + 9'd1;
                    if (body_cnt >= {1'b0, frame_len} + 9'd1) begin
                        parse_phase = PH_HUNT;
                        body_cnt    = 9'd0;
                        decode_frame();
                    end
                end
                default: begin
                    parse_phase = PH_HUNT;
                    if (b == start_byte) begin
                        foreach (kept[i])
                            kept[i] = 8'd0;
                        body_cnt    = 9'd0;
                        parse_phase = PH_LEN;
                    end
                end
            endcase
        endfunction

        function void check_event(input frame_event_t got);
            frame_event_t want;
            if (expected_events.size() == 0) begin
                $error("event with no frame waiting: event_res %0d board_id %0d",
                       got.ev, got.board);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (got.ev !== want.ev) begin
                $error("event_res mismatch: expected %0d, actual %0d", want.ev, got.ev);
                errors++;
            end
            if (got.ok !== want.ok) begin
                $error("success mismatch: expected %0d, actual %0d", want.ok, got.ok);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("device_status mismatch: expected %0d, actual %0d",
                       want.status, got.status);
                errors++;
            end
            if (got.board !== want.board) begin
                $error("board_id mismatch: expected %0d, actual %0d", want.board, got.board);
                errors++;
            end
        endfunction

        function int pending();
            return expected_events.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] event_res;
    logic       success;
    logic [3:0] device_status;
    logic [7:0] board_id;

    frame_decode_tracker tracker;

    // Idling controls: percent of cycles the sender stays idle and the
    // receiver stalls. Changed by the main sequence between phases.
    int         idle_pct = 0;
    int         stall_pct = 0;
    logic       hold_req = 1'b0;
    int         hold_count = 0;
    logic [7:0] cur_start = START_BYTE_RESET;
    int         phase_bytes = 0;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 80;
    localparam int SETTLE_CYCLES = 4;

    serial_frame_event_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_res     (event_res),
        .success       (success),
        .device_status (device_status),
        .board_id      (board_id)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random, and once holds off for a long stretch so
    // that the result register stays full and the block stalls its input.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_req && hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Both channels are sampled in the active region right after the edge,
    // where every signal still holds the value it had at the edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.note_byte(rx_byte);
    end

    always @(posedge clk)
    begin
        frame_event_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.ev     = event_t'(event_res);
            got.ok     = success;
            got.status = device_status;
            got.board  = board_id;
            tracker.check_event(got);
        end
    end

    // Offers one beat. Valid stays high after acceptance so that back-to-back
    // beats are possible; a drain, or an idle spell in the next call, lowers it.
    task automatic send_byte(input logic [7:0] b);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Sends a whole frame: start byte, length, then len+1 body bytes. The
    // first six body bytes are the given positions 2 to 7; any further ones
    // are random filler.
    task automatic send_frame(input logic [7:0] len, input logic [7:0] p2, input logic [7:0] p3,
                              input logic [7:0] p4, input logic [7:0] p5,
                              input logic [7:0] p6, input logic [7:0] p7);
        logic [7:0] fields [0:5];
        int i;
        fields[0] = p2;
        fields[1] = p3;
        fields[2] = p4;
        fields[3] = p5;
        fields[4] = p6;
        fields[5] = p7;
        send_byte(cur_start);
        send_byte(len);
        for (i = 0; i <= len; i++)
            send_byte(i < 6 ? fields[i] : 8'($urandom));
        phase_bytes += len + 3;
    endtask

    // Mostly well-formed frames of the known commands with values picked near
    // the interesting points, plus unknown commands, short frames that leave
    // positions unfilled, rare long frames and stray bytes between frames.
    task automatic send_random_frame();
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] p4;
        logic [7:0] stat;
        logic [7:0] gift;
        int         min_len;
        int         roll;
        if ($urandom_range(99) < 10)
            repeat ($urandom_range(3, 1))
                send_byte(8'($urandom));
        case ($urandom_range(9))
            0, 1:    cmd = 8'($urandom);
            2:       cmd = CMD_QUERY;
            3:       cmd = CMD_SCORE;
            4:       cmd = CMD_END;
            5, 6:    cmd = CMD_PRIZE;
            default: cmd = CMD_ACCOUNT;
        endcase
        if (cmd == CMD_PRIZE)
            min_len = 5;
        else if (cmd == CMD_SCORE || cmd == CMD_ACCOUNT)
            min_len = 2;
        else
            min_len = 1;
        roll = $urandom_range(99);
        if (roll < 3)
            len = 8'($urandom_range(255, 200));
        else if (roll < 75)
            len = 8'(min_len + $urandom_range(2));
        else
            len = 8'($urandom_range(8));
        stat = $urandom_range(1) ? 8'($urandom_range(8'hE9, 8'hDF)) : 8'($urandom);
        gift = $urandom_range(1) ? 8'd0 : 8'($urandom);
        if (cmd == CMD_SCORE)
            p4 = $urandom_range(1) ? SCORE_WIN : 8'($urandom);
        else if (cmd == CMD_PRIZE)
            p4 = ($urandom_range(99) < 80) ? 8'($urandom_range(3)) : 8'($urandom);
        else if (cmd == CMD_ACCOUNT)
            p4 = stat;
        else
            p4 = 8'($urandom);
        send_frame(len, 8'($urandom), cmd, p4, stat, 8'($urandom), gift);
    endtask

    // Stops offering beats and waits until every expected event has come,
    // then gives the block time to settle frames that produce nothing.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_start_byte(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.start_byte = value;
        cur_start = value;
    endtask

    // The run: eight phases, each writing a start byte and setting an idling pattern.
    // Phase 0 opens with the directed frames, phase 4 carries the long
    // receiver hold-off and phase 5 a full pause of the sender.
    initial
    begin
        logic [7:0] start_set [0:7];
        int         p;
        bit         paused;
        tracker = new();
        start_set[0] = 8'hAA;
        start_set[1] = 8'h00;
        start_set[2] = 8'hFF;
        start_set[3] = 8'($urandom);
        start_set[4] = START_BYTE_RESET;
        start_set[5] = 8'h01;
        start_set[6] = 8'($urandom);
        start_set[7] = START_BYTE_RESET;
        paused = 1'b0;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < 8; p++) begin
            drain();
            write_start_byte(start_set[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            phase_bytes = 0;

            if (p == 0) begin
                // A stray byte while hunting, then frames for every command, a repeated prize and two odd frames.
                send_byte(8'h00);
                // Query whose board id equals the start byte: data, not a new frame.
                send_frame(8'd1, 8'hAA, CMD_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
                send_frame(8'd2, 8'hFF, CMD_SCORE, SCORE_WIN, 8'd0, 8'd0, 8'd0);
                send_frame(8'd1, 8'h00, CMD_END, 8'd0, 8'd0, 8'd0, 8'd0);
                send_frame(8'd5, 8'h00, CMD_PRIZE, 8'h07, 8'hE8, 8'h00, 8'h01);
                // Same prize serial again: deduplicated, no event.
                send_frame(8'd2, 8'h00, CMD_PRIZE, 8'h07, 8'd0, 8'd0, 8'd0);
                send_frame(8'd2, 8'h00, CMD_ACCOUNT, 8'hE1, 8'd0, 8'd0, 8'd0);
                // Zero length: one body byte ends the frame, command reads zero.
                send_frame(8'd0, 8'h05, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                send_frame(8'd1, 8'h00, 8'h55, 8'd0, 8'd0, 8'd0, 8'd0);
            end

            if (p == 4)
                hold_req <= 1'b1;

            while (phase_bytes < PHASE_BYTES) begin
                send_random_frame();
                if (p == 5 && !paused && phase_bytes >= PHASE_BYTES / 2) begin
                    paused = 1'b1;
                    drain();
                end
            end
        end

        drain();
        repeat (10)
            @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard limit, far above the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
design/sfed_pkg.sv
design/serial_frame_event_decoder.sv
sim/tb.sv
